// ----- design/bmhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int VALUE_W    = 32;
  localparam int TAG_PORT_W = 16;
  localparam int STATUS_W   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_LAST,
    S_SINK_RD,
    S_SINK_CMP,
    S_FIN
  } state_t;

endpackage

// ----- design/binary_max_heap_priority_queue.sv -----
// A full insert, an empty delete or removing the last item goes straight from S_IDLE to S_FIN.
// An insert alternates S_INS_RD and S_INS_CMP for each level it climbs, until the root or a stop.
// A delete moves the last item in S_DEL_LAST, then alternates S_SINK_RD and S_SINK_CMP as it sinks.
// One transaction at a time: a request is taken only in S_IDLE, which follows S_FIN.
// The next request is taken while the previous response still waits.
// Reset (rst, synchronous) empties the queue; the heap memory is not cleared.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap of signed keys with tags, kept in one 1W/2R synchronous memory.
// The moving item is held in a register; displaced entries are written back.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
  parameter int CAPACITY = 1024,
  parameter int TAG_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     req_valid,
  output logic                                     req_stall,
  input  logic                                     cmd,
  input  logic signed [bmhpq_pkg::VALUE_W-1:0]     key_value,
  input  logic [bmhpq_pkg::TAG_PORT_W-1:0]         key_tag,
  output logic                                     rsp_valid,
  input  logic                                     rsp_stall,
  output logic [bmhpq_pkg::STATUS_W-1:0]           status,
  output logic signed [bmhpq_pkg::VALUE_W-1:0]     removed_value,
  output logic [bmhpq_pkg::TAG_PORT_W-1:0]         removed_tag,
  output logic                                     top_valid,
  output logic signed [bmhpq_pkg::VALUE_W-1:0]     top_value,
  output logic [bmhpq_pkg::TAG_PORT_W-1:0]         top_tag,
  output logic [$clog2(CAPACITY+1)-1:0]            item_count
);
  import bmhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // slot numbers 0..CAPACITY
  localparam int IW = $clog2(CAPACITY);       // memory address
  localparam int TB = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TB-1:0]             tag;
  } entry_t;

  entry_t mem [CAPACITY];

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] k, k_next;
  entry_t item, item_next;
  entry_t top_e;
  entry_t rem_e, rem_next;
  logic [STATUS_W-1:0] st, st_next;

  logic          wr_en;
  logic [CW-1:0] wr_slot;
  entry_t        wr_data;
  logic [CW-1:0] rd_a_slot, rd_b_slot;
  entry_t        rd_a_data, rd_b_data;

  logic [CW:0]   lc, rc;
  logic          has_left, has_right;
  logic          swim_up, take_right, sink_down;
  entry_t        child_e;
  logic [CW-1:0] child_slot;
  logic          req_take, load_rsp;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign load_rsp  = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  // children of slot k; cnt is the heap size during a sink
  assign lc        = {k, 1'b0};
  assign rc        = lc + (CW+1)'(1);
  assign has_left  = lc <= {1'b0, cnt};
  assign has_right = lc < {1'b0, cnt};

  assign swim_up    = $signed(rd_a_data.value) < $signed(item.value);
  assign take_right = has_right && ($signed(rd_a_data.value) < $signed(rd_b_data.value));
  assign child_e    = take_right ? rd_b_data : rd_a_data;
  assign child_slot = take_right ? rc[CW-1:0] : lc[CW-1:0];
  assign sink_down  = $signed(item.value) < $signed(child_e.value);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          if (cmd == CMD_INSERT) begin
            state_next = (cnt == CAP_C) ? S_FIN : S_INS_RD;
          end else begin
            state_next = (cnt <= ONE_C) ? S_FIN : S_DEL_LAST;
          end
        end
      end
      S_INS_RD:   state_next = (k == ONE_C) ? S_FIN : S_INS_CMP;
      S_INS_CMP:  state_next = swim_up ? S_INS_RD : S_FIN;
      S_DEL_LAST: state_next = S_SINK_RD;
      S_SINK_RD:  state_next = has_left ? S_SINK_CMP : S_FIN;
      S_SINK_CMP: state_next = sink_down ? S_SINK_RD : S_FIN;
      S_FIN:      state_next = load_rsp ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_next  = cnt;
    k_next    = k;
    item_next = item;
    rem_next  = rem_e;
    st_next   = st;
    wr_en     = 1'b0;
    wr_slot   = k;
    wr_data   = item;
    rd_a_slot = k >> 1;
    rd_b_slot = cnt;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          rem_next = '0;
          st_next  = ST_OK;
          if (cmd == CMD_INSERT) begin
            if (cnt == CAP_C) begin
              st_next = ST_FULL;
            end else begin
              item_next.value = key_value;
              item_next.tag   = key_tag[TB-1:0];
              k_next          = cnt + ONE_C;
              cnt_next        = cnt + ONE_C;
            end
          end else begin
            if (cnt == '0) begin
              st_next = ST_EMPTY;
            end else begin
              rem_next = top_e;
              cnt_next = cnt - ONE_C;
            end
          end
        end
      end
      S_INS_RD: begin
        // root reached: place the item
        if (k == ONE_C) begin
          wr_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (swim_up) begin
          wr_data = rd_a_data;
          k_next  = k >> 1;
        end
      end
      S_DEL_LAST: begin
        item_next = rd_b_data;
        k_next    = ONE_C;
      end
      S_SINK_RD: begin
        rd_a_slot = lc[CW-1:0];
        rd_b_slot = has_right ? rc[CW-1:0] : lc[CW-1:0];
        if (!has_left) begin
          wr_en = 1'b1;
        end
      end
      S_SINK_CMP: begin
        wr_en = 1'b1;
        if (sink_down) begin
          wr_data = child_e;
          k_next  = child_slot;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(wr_slot - ONE_C)] <= wr_data;
    end
    rd_a_data <= mem[IW'(rd_a_slot - ONE_C)];
    rd_b_data <= mem[IW'(rd_b_slot - ONE_C)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    item  <= item_next;
    rem_e <= rem_next;
    st    <= st_next;
    // copy of slot 1 for the top report
    if (wr_en && wr_slot == ONE_C) begin
      top_e <= wr_data;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      status        <= st;
      removed_value <= rem_e.value;
      removed_tag   <= TAG_PORT_W'(rem_e.tag);
      item_count    <= cnt;
      top_valid     <= (cnt != '0);
      top_value     <= (cnt != '0) ? top_e.value : '0;
      top_tag       <= (cnt != '0) ? TAG_PORT_W'(top_e.tag) : '0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_C)
    else $error("item count above capacity");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_slot >= ONE_C && wr_slot <= cnt))
    else $error("heap write outside occupied slots");

  a_sink_child: assert property (@(posedge clk) disable iff (rst)
    state == S_SINK_CMP |-> lc <= {1'b0, cnt})
    else $error("sink compare without a child");

  a_top_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (top_valid == (item_count != '0)))
    else $error("top flag disagrees with count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> item_count == CAP_C)
    else $error("full status with room left");

endmodule
